/* rtl/soa_pkg.sv */
// Slab object allocator: shared types, codes and fixed constants.
// No dependencies; compiled first.
package soa_pkg;

  localparam int ADDR_W     = 17;     // pool address width
  localparam int OFF_W      = 14;     // slab-relative offset width
  localparam int SIZE_W     = 14;     // object size register width
  localparam int COLOR_W    = 9;      // color offset width
  localparam int SLAB_BYTES = 16384;  // slab i starts at i*SLAB_BYTES
  localparam int SLAB_SHIFT = 14;     // log2(SLAB_BYTES)
  localparam int COLOR_SPAN = 512;
  localparam int COLOR_STEP = 64;
  localparam int MIN_OBJECT = 16;
  localparam int SIZE_RESET = 64;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_SLAB   = 2'd1,
    ST_FREED     = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TAG_EMPTY   = 2'd0,
    TAG_PARTIAL = 2'd1,
    TAG_FULL    = 2'd2,
    TAG_UNUSED  = 2'd3
  } tag_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_FILL,
    S_POP,
    S_POP_WAIT,
    S_FREE,
    S_UNLINK,
    S_WALK,
    S_PUSH
  } state_t;

endpackage

/* rtl/soa_ifs.sv */
// Valid/ready channel interfaces for the allocator request and response.
// Depends on soa_pkg for field widths.
interface soa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [soa_pkg::ADDR_W-1:0] address;
  modport source (output valid, output operation, output address, input ready);
  modport sink   (input valid, input operation, input address, output ready);
endinterface

interface soa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [soa_pkg::ADDR_W-1:0] granted_address;
  logic [1:0]                 status;
  logic                       new_slab;
  modport source (output valid, output granted_address, output status, output new_slab,
                  input ready);
  modport sink   (input valid, input granted_address, input status, input new_slab,
                  output ready);
endinterface

/* rtl/slab_object_allocator_core.sv */
// Slab object allocator core: sequencer, per-slab list state, free-offset memory.
// Depends on soa_pkg and the channel interfaces in soa_ifs.sv.
//
// One request is in flight at a time: in_ch.ready is high only while the
// sequencer is idle and no response waits on out_ch. An allocate from a
// partial slab decides, pops with a memory read and responds; when its last
// object goes, the slab is unlinked and pushed onto the full list, and an
// empty slab that is taken is first moved onto the partial list. Building a new
// slab fills its free stack one offset per cycle through the single memory
// write port, min(OBJECT_SLOTS, (16384 - color) / size) offsets, before the pop.
// A free pushes its offset back; for a move to another list it unlinks the slab,
// walking the source list slab by slab (at most SLAB_COUNT), and pushes it
// onto the new list. The object size register may only be written
// while idle; values below 16 act as 16.
module slab_object_allocator_core #(
  parameter int SLAB_COUNT   = 8,
  parameter int OBJECT_SLOTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [soa_pkg::SIZE_W-1:0]  cfg_wdata,
  soa_req_if.sink                     in_ch,
  soa_rsp_if.source                   out_ch
);
  import soa_pkg::*;

  // slab index with room for the none marker
  localparam int LW    = $clog2(SLAB_COUNT + 1);
  localparam int SW    = (SLAB_COUNT > 1) ? $clog2(SLAB_COUNT) : 1;
  localparam int CW    = $clog2(OBJECT_SLOTS + 1);
  localparam int DEPTH = SLAB_COUNT * OBJECT_SLOTS;
  localparam int MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LW-1:0] NONE = LW'(SLAB_COUNT);

  // free-offset stacks, one region of OBJECT_SLOTS per slab
  logic [OFF_W-1:0] mem [DEPTH];
  logic             mem_we;
  logic [MAW-1:0]   mem_waddr, mem_raddr;
  logic [OFF_W-1:0] mem_wdata, mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  state_t             state_r, state_nxt;
  logic [SIZE_W-1:0]  size_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [LW-1:0]      s_r, s_nxt, p_r, p_nxt;
  logic               fresh_r, fresh_nxt, pop_pend_r, pop_pend_nxt;
  tag_t               tgt_r, tgt_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [15:0]        off_r, off_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic [LW-1:0]      built_r, built_nxt;
  logic [LW-1:0]      partial_r, partial_nxt, empty_r, empty_nxt, full_r, full_nxt;
  logic [LW-1:0]      link_r [SLAB_COUNT];
  logic [LW-1:0]      link_nxt [SLAB_COUNT];
  tag_t               tag_r [SLAB_COUNT];
  tag_t               tag_nxt [SLAB_COUNT];
  logic [CW-1:0]      fc_r [SLAB_COUNT];
  logic [CW-1:0]      fc_nxt [SLAB_COUNT];
  logic [CW-1:0]      total_r [SLAB_COUNT];
  logic [CW-1:0]      total_nxt [SLAB_COUNT];

  logic               ovalid_r, ovalid_nxt;
  logic [ADDR_W-1:0]  ogrant_r, ogrant_nxt;
  status_t            ostat_r, ostat_nxt;
  logic               onew_r, onew_nxt;

  logic [SIZE_W-1:0]  eff_size;
  logic [SW-1:0]      si;
  logic [2:0]         q;
  logic [SW-1:0]      qi;

  assign eff_size = (size_r < SIZE_W'(MIN_OBJECT)) ? SIZE_W'(MIN_OBJECT) : size_r;
  assign si       = s_r[SW-1:0];
  assign q        = addr_r[ADDR_W-1:SLAB_SHIFT];
  // slab number of a free as a slab index; its lookups only matter once q < built_r
  assign qi       = SW'(32'(q));

  assign in_ch.ready            = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid           = ovalid_r;
  assign out_ch.granted_address = ogrant_r;
  assign out_ch.status          = ostat_r;
  assign out_ch.new_slab        = onew_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      size_r     <= SIZE_W'(SIZE_RESET);
      color_r    <= '0;
      built_r    <= '0;
      partial_r  <= NONE;
      empty_r    <= NONE;
      full_r     <= NONE;
      ovalid_r   <= 1'b0;
      pop_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_we) size_r <= cfg_wdata;
      color_r    <= color_nxt;
      built_r    <= built_nxt;
      partial_r  <= partial_nxt;
      empty_r    <= empty_nxt;
      full_r     <= full_nxt;
      ovalid_r   <= ovalid_nxt;
      pop_pend_r <= pop_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      addr_r <= in_ch.address;
    end
    s_r      <= s_nxt;
    p_r      <= p_nxt;
    fresh_r  <= fresh_nxt;
    tgt_r    <= tgt_nxt;
    k_r      <= k_nxt;
    off_r    <= off_nxt;
    link_r   <= link_nxt;
    tag_r    <= tag_nxt;
    fc_r     <= fc_nxt;
    total_r  <= total_nxt;
    ogrant_r <= ogrant_nxt;
    ostat_r  <= ostat_nxt;
    onew_r   <= onew_nxt;
  end

  always_comb begin
    logic [LW-1:0] head;
    logic [16:0]   off_n;
    logic [CW-1:0] fc;
    state_nxt    = state_r;
    s_nxt        = s_r;
    p_nxt        = p_r;
    fresh_nxt    = fresh_r;
    pop_pend_nxt = pop_pend_r;
    tgt_nxt      = tgt_r;
    k_nxt        = k_r;
    off_nxt      = off_r;
    color_nxt    = color_r;
    built_nxt    = built_r;
    partial_nxt  = partial_r;
    empty_nxt    = empty_r;
    full_nxt     = full_r;
    link_nxt     = link_r;
    tag_nxt      = tag_r;
    fc_nxt       = fc_r;
    total_nxt    = total_r;
    ovalid_nxt   = ovalid_r && !out_ch.ready;
    ogrant_nxt   = ogrant_r;
    ostat_nxt    = ostat_r;
    onew_nxt     = onew_r;
    mem_we       = 1'b0;
    mem_waddr    = MAW'(32'(si) * OBJECT_SLOTS + 32'(k_r));
    mem_wdata    = off_r[OFF_W-1:0];
    mem_raddr    = MAW'(32'(si) * OBJECT_SLOTS + 32'(fc_r[si]) - 1);
    fc           = fc_r[si];
    off_n        = 17'(off_r) + 17'(eff_size);

    unique case (tag_r[si])
      TAG_FULL:    head = full_r;
      TAG_PARTIAL: head = partial_r;
      default:     head = empty_r;
    endcase

    unique case (state_r)
      S_IDLE: begin
        fresh_nxt    = 1'b0;
        pop_pend_nxt = 1'b0;
        // response fields are held while a transfer waits on out_ch
        if (in_ch.valid && in_ch.ready) begin
          ogrant_nxt = '0;
          onew_nxt   = 1'b0;
          state_nxt  = (in_ch.operation == OP_FREE) ? S_FREE : S_ALLOC;
        end
      end

      S_ALLOC: begin
        if (partial_r != NONE) begin
          s_nxt     = partial_r;
          state_nxt = S_POP;
        end else if (empty_r != NONE) begin
          // empty slab is the head of its list: unlink, then onto partial
          s_nxt        = empty_r;
          tgt_nxt      = TAG_PARTIAL;
          pop_pend_nxt = 1'b1;
          state_nxt    = S_UNLINK;
        end else if (32'(built_r) >= SLAB_COUNT ||
                     32'(color_r) + 32'(eff_size) > SLAB_BYTES) begin
          ostat_nxt  = ST_NO_SLAB;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          s_nxt     = built_r;
          k_nxt     = '0;
          off_nxt   = 16'(color_r);
          state_nxt = S_FILL;
        end
      end

      // one stack entry per cycle, ascending offsets
      S_FILL: begin
        mem_we  = 1'b1;
        k_nxt   = k_r + 1'b1;
        off_nxt = off_n[15:0];
        if (32'(k_r) + 1 >= OBJECT_SLOTS ||
            32'(off_n) + 32'(eff_size) > SLAB_BYTES) begin
          total_nxt[si] = k_r + 1'b1;
          fc_nxt[si]    = k_r + 1'b1;
          built_nxt     = built_r + 1'b1;
          color_nxt     = (32'(color_r) + COLOR_STEP >= COLOR_SPAN) ? '0 :
                          COLOR_W'(32'(color_r) + COLOR_STEP);
          fresh_nxt     = 1'b1;
          pop_pend_nxt  = 1'b1;
          tgt_nxt       = TAG_PARTIAL;
          state_nxt     = S_PUSH;
        end
      end

      S_POP: begin
        if (fc == '0) begin
          ostat_nxt  = ST_NO_SLAB;
          onew_nxt   = 1'b0;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          fc_nxt[si] = fc - 1'b1;
          state_nxt  = S_POP_WAIT;
        end
      end

      S_POP_WAIT: begin
        ogrant_nxt = ADDR_W'(32'(si) * SLAB_BYTES + 32'(mem_rdata_r));
        ostat_nxt  = ST_ALLOCATED;
        onew_nxt   = fresh_r;
        if (fc == '0) begin
          tgt_nxt   = TAG_FULL;
          state_nxt = S_UNLINK;
        end else begin
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      S_FREE: begin
        s_nxt = LW'(q);
        fc    = fc_r[qi];
        if (32'(q) >= 32'(built_r) || tag_r[qi] == TAG_EMPTY ||
            fc >= total_r[qi] || 32'(fc) >= OBJECT_SLOTS) begin
          ostat_nxt  = ST_IGNORED;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = MAW'(32'(q) * OBJECT_SLOTS + 32'(fc));
          mem_wdata  = addr_r[OFF_W-1:0];
          fc_nxt[qi] = fc + 1'b1;
          ostat_nxt  = ST_FREED;
          if (fc + 1'b1 == total_r[qi]) begin
            tgt_nxt   = TAG_EMPTY;
            state_nxt = S_UNLINK;
          end else if (tag_r[qi] == TAG_FULL) begin
            tgt_nxt   = TAG_PARTIAL;
            state_nxt = S_UNLINK;
          end else begin
            ovalid_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end

      S_UNLINK: begin
        if (head == s_r) begin
          unique case (tag_r[si])
            TAG_FULL:    full_nxt    = link_r[si];
            TAG_PARTIAL: partial_nxt = link_r[si];
            default:     empty_nxt   = link_r[si];
          endcase
          state_nxt = S_PUSH;
        end else begin
          p_nxt     = head;
          state_nxt = S_WALK;
        end
      end

      // one list node per cycle
      S_WALK: begin
        if (p_r >= NONE) begin
          state_nxt = S_PUSH;
        end else if (link_r[p_r[SW-1:0]] == s_r) begin
          link_nxt[p_r[SW-1:0]] = link_r[si];
          state_nxt             = S_PUSH;
        end else begin
          p_nxt = link_r[p_r[SW-1:0]];
        end
      end

      S_PUSH: begin
        tag_nxt[si] = tgt_r;
        unique case (tgt_r)
          TAG_FULL: begin
            link_nxt[si] = full_r;
            full_nxt     = s_r;
          end
          TAG_PARTIAL: begin
            link_nxt[si] = partial_r;
            partial_nxt  = s_r;
          end
          default: begin
            link_nxt[si] = empty_r;
            empty_nxt    = s_r;
          end
        endcase
        if (pop_pend_r) begin
          pop_pend_nxt = 1'b0;
          state_nxt    = S_POP;
        end else begin
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* rtl/soa_checker.sv */
// Port-level checks for the slab object allocator, bound into slab_object_allocator_core.
// Depends on soa_pkg and slab_object_allocator_core.
module soa_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [soa_pkg::ADDR_W-1:0] granted_address,
  input logic [1:0]                 status,
  input logic                       new_slab
);
  import soa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(granted_address) && $stable(status))
    else $error("stalled response changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_ALLOCATED |-> granted_address == '0 && !new_slab)
    else $error("address or new_slab without allocation");

  a_no_wait_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken while response pending");
endmodule

bind slab_object_allocator_core soa_checker u_soa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .granted_address (out_ch.granted_address),
  .status          (out_ch.status),
  .new_slab        (out_ch.new_slab)
);

/* dv/tb_top.sv */
// Self-checking testbench for slab_object_allocator_core.
// Depends on soa_pkg and the channel interfaces in soa_ifs.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import soa_pkg::*;

  localparam int NSLAB      = 8;
  localparam int NOBJ       = 1024;
  localparam int NONE       = 255;
  localparam int CYCLE_CAP  = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  soa_req_if req ();
  soa_rsp_if rsp ();

  slab_object_allocator_core #(.SLAB_COUNT(NSLAB), .OBJECT_SLOTS(NOBJ)) uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(req.sink), .out_ch(rsp.source)
  );

  always #1 clk = ~clk;

  // grant expected for each accepted request, oldest first
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           st;
    logic              fresh;
  } grant_t;

  grant_t grant_q[$];
  logic [ADDR_W-1:0] live_q[$];   // addresses currently handed out
  logic [ADDR_W-1:0] last_freed;
  int errors = 0;
  int cycles = 0;
  int n_items = 0, n_alloc = 0, n_freed = 0, n_ignored = 0, n_noroom = 0, n_built = 0;
  int send_idle = 0, recv_idle = 0;

  // --------------------------------------------------------------------
  // pool shadow state
  // --------------------------------------------------------------------
  int unsigned obj_size, color_nxt, built, p_head, e_head, f_head;
  int unsigned s_link[NSLAB], s_tag[NSLAB], s_cnt[NSLAB], s_tot[NSLAB];
  logic [OFF_W-1:0] off_stack[NSLAB*NOBJ];

  function automatic int unsigned head_get(int unsigned tag);
    if (tag == TAG_FULL) return f_head;
    if (tag == TAG_PARTIAL) return p_head;
    return e_head;
  endfunction

  function automatic void head_set(int unsigned tag, int unsigned v);
    if (tag == TAG_FULL) f_head = v;
    else if (tag == TAG_PARTIAL) p_head = v;
    else e_head = v;
  endfunction

  function automatic void list_push(int unsigned s, int unsigned tag);
    s_link[s] = head_get(tag);
    head_set(tag, s);
    s_tag[s] = tag;
  endfunction

  function automatic void list_drop(int unsigned s);
    int unsigned p;
    p = head_get(s_tag[s]);
    if (p == s) begin
      head_set(s_tag[s], s_link[s]);
      return;
    end
    for (int n = 0; n < NSLAB && p < NSLAB; n++) begin
      if (s_link[p] == s) begin
        s_link[p] = s_link[s];
        return;
      end
      p = s_link[p];
    end
  endfunction

  function automatic int unsigned slab_build();
    int unsigned s, c, sz, cnt;
    s = built;
    c = color_nxt;
    sz = (obj_size < MIN_OBJECT) ? MIN_OBJECT : obj_size;
    cnt = 0;
    if (s >= NSLAB) return NONE;
    if (c < SLAB_BYTES) cnt = (SLAB_BYTES - c) / sz;
    if (cnt > NOBJ) cnt = NOBJ;
    if (cnt == 0) return NONE;
    color_nxt += COLOR_STEP;
    if (color_nxt >= COLOR_SPAN) color_nxt = 0;
    for (int unsigned k = 0; k < cnt; k++) off_stack[s*NOBJ + k] = OFF_W'(c + k*sz);
    s_tot[s] = cnt;
    s_cnt[s] = cnt;
    built = s + 1;
    list_push(s, TAG_PARTIAL);
    return s;
  endfunction

  function automatic grant_t pool_predict(logic op, logic [ADDR_W-1:0] a);
    grant_t g;
    int unsigned s, adr;
    logic fr;
    g = '{addr: '0, st: ST_ALLOCATED, fresh: 1'b0};
    fr = 1'b0;
    if (op == OP_ALLOC) begin
      s = p_head;
      if (s >= NSLAB) begin
        s = e_head;
        if (s < NSLAB) begin
          list_drop(s);
          list_push(s, TAG_PARTIAL);
        end else begin
          s = slab_build();
          fr = 1'b1;
        end
      end
      if (s >= NSLAB || s_cnt[s] == 0) begin
        g.st = ST_NO_SLAB;
        return g;
      end
      s_cnt[s]--;
      adr = s*SLAB_BYTES + off_stack[s*NOBJ + s_cnt[s]];
      if (s_cnt[s] == 0) begin
        list_drop(s);
        list_push(s, TAG_FULL);
      end
      g.addr = ADDR_W'(adr);
      g.fresh = fr;
      return g;
    end
    s = a / SLAB_BYTES;
    if (s >= built || s_tag[s] == TAG_EMPTY || s_cnt[s] >= s_tot[s] || s_cnt[s] >= NOBJ) begin
      g.st = ST_IGNORED;
      return g;
    end
    off_stack[s*NOBJ + s_cnt[s]] = OFF_W'(a - s*SLAB_BYTES);
    s_cnt[s]++;
    if (s_cnt[s] == s_tot[s]) begin
      list_drop(s);
      list_push(s, TAG_EMPTY);
    end else if (s_tag[s] == TAG_FULL) begin
      list_drop(s);
      list_push(s, TAG_PARTIAL);
    end
    g.st = ST_FREED;
    return g;
  endfunction

  // --------------------------------------------------------------------
  // request side: one transfer per call, valid held high on back-to-back
  // --------------------------------------------------------------------
  task automatic send_item(logic op, logic [ADDR_W-1:0] a);
    grant_t g;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.address   <= a;
    do @(posedge clk); while (!req.ready);
    g = pool_predict(op, a);
    grant_q.push_back(g);
    n_items++;
    case (g.st)
      ST_ALLOCATED: begin
        n_alloc++;
        live_q.push_back(g.addr);
        if (g.fresh) n_built++;
      end
      ST_FREED:   n_freed++;
      ST_IGNORED: n_ignored++;
      default:    n_noroom++;
    endcase
  endtask

  // drop valid and wait for every outstanding response
  task automatic drain();
    @(negedge clk);
    req.valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write; only called once the block is idle
  task automatic write_size(logic [SIZE_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    obj_size = v;
  endtask

  // free one handed-out object, chosen at random
  task automatic free_live();
    int i;
    logic [ADDR_W-1:0] a;
    i = $urandom_range(0, live_q.size() - 1);
    a = live_q[i];
    live_q.delete(i);
    last_freed = a;
    send_item(OP_FREE, a);
  endtask

  // response side: random back-pressure
  always @(negedge clk) rsp.ready <= ($urandom_range(0, 99) >= recv_idle);

  // response checker
  always @(posedge clk) begin
    if (rst_n && rsp.valid && rsp.ready) begin
      if (grant_q.size() == 0) begin
        $error("response with nothing expected");
        errors++;
      end else begin
        grant_t g;
        g = grant_q.pop_front();
        if (rsp.granted_address !== g.addr) begin
          $error("granted_address exp %h got %h", g.addr, rsp.granted_address);
          errors++;
        end
        if (rsp.status !== g.st) begin
          $error("status exp %0d got %0d", g.st, rsp.status);
          errors++;
        end
        if (rsp.new_slab !== g.fresh) begin
          $error("new_slab exp %0d got %0d", g.fresh, rsp.new_slab);
          errors++;
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------
  task automatic test_directed();
    logic [ADDR_W-1:0] a;
    send_item(OP_ALLOC, '1);          // first alloc builds slab 0, address ignored
    send_item(OP_FREE, 17'h18000);    // foreign free: slab 6 not built
    send_item(OP_FREE, '1);           // top of the pool, unbuilt slab
    a = live_q.pop_front();
    send_item(OP_FREE, a);            // object back, slab goes empty
    send_item(OP_FREE, a);            // free into an empty slab is ignored
    send_item(OP_ALLOC, '0);          // empty slab reused
    send_item(OP_ALLOC, 17'h0AAAA);
    send_item(OP_FREE, 17'h00000);    // unaligned / double free, pushed as given
    send_item(OP_FREE, 17'h03FFF);
    write_size(SIZE_W'(8192));        // size 8192: 2 or 1 objects per slab
    write_size(SIZE_W'(0));           // below minimum acts as 16
    write_size(SIZE_W'(8192));
  endtask

  // random phase: mostly legal alloc/free with some noise
  task automatic test_random(int n, int alloc_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct || live_q.size() == 0)
        send_item(OP_ALLOC, ADDR_W'($urandom_range(0, 131071)));
      else if (r < 92)
        free_live();
      else if (r < 96)
        send_item(OP_FREE, last_freed);          // double free
      else
        send_item(OP_FREE, ADDR_W'($urandom_range(0, 131071)));
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.operation = OP_ALLOC;
    req.address = '0;
    rsp.ready = 1'b0;
    obj_size = SIZE_RESET;
    color_nxt = 0;
    built = 0;
    p_head = NONE;
    e_head = NONE;
    f_head = NONE;
    last_freed = '0;
    for (int i = 0; i < NSLAB; i++) begin
      s_link[i] = 0; s_tag[i] = 0; s_cnt[i] = 0; s_tot[i] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender mostly busy, receiver stalls often
    send_idle = 8;
    recv_idle = 53;
    test_directed();
    test_random(100, 75);
    write_size(SIZE_W'(16383));        // no room once color is nonzero
    test_random(40, 85);
    write_size(SIZE_W'(0));
    test_random(80, 60);

    // sender gaps, receiver mostly ready
    send_idle = 53;
    recv_idle = 8;
    write_size(SIZE_W'(4096));
    test_random(120, 70);
    write_size(SIZE_W'(16));
    test_random(120, 50);

    // full rate both sides
    send_idle = 0;
    recv_idle = 0;
    write_size(SIZE_W'(512));
    test_random(120, 60);
    write_size(SIZE_W'(8192));
    test_random(60, 30);
    drain();

    $display("covered %0d transfers: %0d grants (%0d new slabs), %0d out of slabs,",
             n_items, n_alloc, n_built, n_noroom);
    $display("  %0d frees, %0d ignored frees, %0d of %0d slabs built", n_freed,
             n_ignored, built, NSLAB);
    if (errors == 0 && grant_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

/* filelist.f */
rtl/soa_pkg.sv
rtl/soa_ifs.sv
rtl/slab_object_allocator_core.sv
rtl/soa_checker.sv
dv/tb_top.sv
